// ===== design/hsl_to_rgb_converter_defines.svh =====
// Assertion macros used by the HSL to RGB converter RTL.
`ifndef HSL_TO_RGB_CONVERTER_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define H2R_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("h2r assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define H2R_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("h2r assertion failed");

`else

`define H2R_ASSERT_NOW(label, ante, cons)
`define H2R_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/h2r_pkg.sv =====
// Types and constants for the HSL to RGB converter.
package h2r_pkg;

	// Hue in 1/64 degree, one full turn and one 60 degree sector.
	localparam logic [14:0] HUE_TURN   = 15'd23040;
	localparam logic [14:0] HUE_SECTOR = 15'd3840;
	// 1.0 in Q0.8.
	localparam logic [8:0]  UNIT_Q8    = 9'd256;

	typedef struct packed {
		logic [14:0] hue;
		logic [8:0]  saturation;
		logic [8:0]  lightness;
	} hsl_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// 60 degree hue sectors; odd sectors have a falling secondary.
	typedef enum logic [2:0] {
		SEC_R_Y = 3'd0,
		SEC_Y_G = 3'd1,
		SEC_G_C = 3'd2,
		SEC_C_B = 3'd3,
		SEC_B_M = 3'd4,
		SEC_M_R = 3'd5
	} sector_t;

endpackage

// ===== design/hsl_to_rgb_converter.sv =====
// HSL to RGB converter: six-stage pipeline, one color per clock while rgb is not stalled.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  hsl     | in        | hsl_valid / hsl_stall | hue 15b, saturation 9b, lightness 9b
//  rgb     | out       | rgb_valid / rgb_stall | red, green, blue, 8b each
//
// Throughput is one item per clock while rgb_stall is low. The six register stages are sector split,
// chroma product and reciprocal multiply, quotient correction, component products, channel sum,
// and scale and clamp.
// Reset (arst_n low) empties the pipeline; payload registers are not reset.
// A stall on rgb holds only the stages that are full up to the first bubble,
// so bubbles are squeezed out and hsl_stall rises only when every stage is full.
module hsl_to_rgb_converter #(
	parameter int FRAC_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hsl_valid,
	output logic          hsl_stall,
	input  h2r_pkg::hsl_t hsl,
	output logic          rgb_valid,
	input  logic          rgb_stall,
	output h2r_pkg::rgb_t rgb
);
	import h2r_pkg::*;

`include "hsl_to_rgb_converter_defines.svh"

	// Width of rem scaled to a 1/256 step base before the divide by 15.
	localparam int NW     = (FRAC_BITS >= 8) ? FRAC_BITS + 4 : 12;
	localparam int SH_UP  = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
	localparam int SH_DN  = (FRAC_BITS >= 8) ? 0 : 8 - FRAC_BITS;
	// Reciprocal of 15, K fraction bits; off by at most one below.
	localparam int K      = NW + 4;
	localparam int RW     = NW + 1;
	localparam int PW     = NW + RW;
	localparam longint RECIP = (longint'(1) << K) / 15;
	// Working scale Q(16+FRAC_BITS); a channel sum never exceeds 1.0.
	localparam int VW     = FRAC_BITS + 17;
	localparam int XW     = FRAC_BITS + 18;
	localparam int SW     = XW + 8;

	// Stage enables, back to front.
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	// Stage 1: wrap hue, clamp inputs, split sector, fold lightness.
	logic [14:0] hue_w;
	logic [8:0]  sat_c, lig_c;
	logic [9:0]  two_l;
	sector_t     sector_d;
	logic [14:0] base_d;
	sector_t     sector_s1;
	logic [11:0] rem_s1;
	logic [8:0]  sat_s1, lig_s1, t_s1;
	logic [8:0]  t_d;

	// Stage 2
	logic [NW-1:0]        n_d;
	logic [PW-1:0]        prod_d;
	sector_t              sector_s2;
	logic [NW-1:0]        n_s2;
	logic [FRAC_BITS-1:0] q0_s2;
	logic [16:0]          c_s2;
	logic [8:0]           lig_s2;

	// Stage 3
	logic [NW-1:0]        r_d;
	logic [FRAC_BITS-1:0] frac_d;
	logic [17:0]          lm_d;
	sector_t              sector_s3;
	logic [FRAC_BITS:0]   wx_s3;
	logic [16:0]          c_s3;
	logic [VW-1:0]        l_s3;

	// Stage 4
	sector_t       sector_s4;
	logic [XW-1:0] px_s4;
	logic [VW-1:0] pc_s4;
	logic [VW-1:0] l_s4;

	// Stage 5
	logic [XW-1:0] cr_d, cg_d, cb_d;
	logic [XW-1:0] vr_s5, vg_s5, vb_s5;

	// Stage 6
	logic [SW-1:0] sr_d, sg_d, sb_d;
	rgb_t          rgb_d;
	rgb_t          rgb_s6;

	assign en_s6     = !vld_s6 || !rgb_stall;
	assign en_s5     = !vld_s5 || en_s6;
	assign en_s4     = !vld_s4 || en_s5;
	assign en_s3     = !vld_s3 || en_s4;
	assign en_s2     = !vld_s2 || en_s3;
	assign en_s1     = !vld_s1 || en_s2;
	assign hsl_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= hsl_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
		end
	end

	// ---- stage 1 ----
	always_comb begin
		hue_w = (hsl.hue >= HUE_TURN) ? hsl.hue - HUE_TURN : hsl.hue;
		sat_c = (hsl.saturation > UNIT_Q8) ? UNIT_Q8 : hsl.saturation;
		lig_c = (hsl.lightness > UNIT_Q8) ? UNIT_Q8 : hsl.lightness;
		priority if (hue_w >= 15'(5 * HUE_SECTOR)) begin
			sector_d = SEC_M_R;
			base_d   = 15'(5 * HUE_SECTOR);
		end else if (hue_w >= 15'(4 * HUE_SECTOR)) begin
			sector_d = SEC_B_M;
			base_d   = 15'(4 * HUE_SECTOR);
		end else if (hue_w >= 15'(3 * HUE_SECTOR)) begin
			sector_d = SEC_C_B;
			base_d   = 15'(3 * HUE_SECTOR);
		end else if (hue_w >= 15'(2 * HUE_SECTOR)) begin
			sector_d = SEC_G_C;
			base_d   = 15'(2 * HUE_SECTOR);
		end else if (hue_w >= HUE_SECTOR) begin
			sector_d = SEC_Y_G;
			base_d   = HUE_SECTOR;
		end else begin
			sector_d = SEC_R_Y;
			base_d   = 15'd0;
		end
		// t = 1 - |2l - 1| in Q0.8
		two_l = {lig_c, 1'b0};
		t_d   = (two_l >= 10'(UNIT_Q8)) ? 9'(10'd512 - two_l) : two_l[8:0];
	end

	always_ff @(posedge clk) begin
		if (en_s1 && hsl_valid) begin
			sector_s1 <= sector_d;
			rem_s1    <= 12'(hue_w - base_d);
			sat_s1    <= sat_c;
			lig_s1    <= lig_c;
			t_s1      <= t_d;
		end
	end

	// ---- stage 2: chroma and reciprocal multiply ----
	// frac = floor(rem * 2^F / 3840) = floor(floor(rem * 2^F / 256) / 15)
	always_comb begin
		if (FRAC_BITS >= 8) n_d = NW'(rem_s1) << SH_UP;
		else                n_d = NW'(rem_s1) >> SH_DN;
		prod_d = PW'(n_d) * PW'(RECIP);
	end

	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			sector_s2 <= sector_s1;
			n_s2      <= n_d;
			q0_s2     <= prod_d[K +: FRAC_BITS];
			c_s2      <= 17'(t_s1 * sat_s1);
			lig_s2    <= lig_s1;
		end
	end

	// ---- stage 3: quotient correction, secondary weight, offset ----
	always_comb begin
		r_d    = n_s2 - ((NW'(q0_s2) << 4) - NW'(q0_s2));
		frac_d = (r_d >= NW'(15)) ? q0_s2 + FRAC_BITS'(1) : q0_s2;
		// 2l - c in Q0.16, never negative for clamped inputs
		lm_d   = {lig_s2, 9'd0} - 18'(c_s2);
	end

	always_ff @(posedge clk) begin
		if (en_s3 && vld_s2) begin
			sector_s3 <= sector_s2;
			wx_s3     <= sector_s2[0] ? (FRAC_BITS + 1)'(1 << FRAC_BITS) - {1'b0, frac_d}
			                          : {1'b0, frac_d};
			c_s3      <= c_s2;
			l_s3      <= VW'(lm_d) << (FRAC_BITS - 1);
		end
	end

	// ---- stage 4: component products ----
	always_ff @(posedge clk) begin
		if (en_s4 && vld_s3) begin
			sector_s4 <= sector_s3;
			px_s4     <= XW'(c_s3) * XW'(wx_s3);
			pc_s4     <= VW'(c_s3) << FRAC_BITS;
			l_s4      <= l_s3;
		end
	end

	// ---- stage 5: place components, add m ----
	always_comb begin
		cr_d = '0;
		cg_d = '0;
		cb_d = '0;
		unique case (sector_s4)
			SEC_R_Y: begin cr_d = XW'(pc_s4); cg_d = px_s4; end
			SEC_Y_G: begin cr_d = px_s4; cg_d = XW'(pc_s4); end
			SEC_G_C: begin cg_d = XW'(pc_s4); cb_d = px_s4; end
			SEC_C_B: begin cg_d = px_s4; cb_d = XW'(pc_s4); end
			SEC_B_M: begin cr_d = px_s4; cb_d = XW'(pc_s4); end
			SEC_M_R: begin cr_d = XW'(pc_s4); cb_d = px_s4; end
			default: begin cr_d = '0; cg_d = '0; cb_d = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s5 && vld_s4) begin
			vr_s5 <= cr_d + XW'(l_s4);
			vg_s5 <= cg_d + XW'(l_s4);
			vb_s5 <= cb_d + XW'(l_s4);
		end
	end

	// ---- stage 6: times 255, drop fraction, clamp ----
	always_comb begin
		sr_d = (SW'(vr_s5) << 8) - SW'(vr_s5);
		sg_d = (SW'(vg_s5) << 8) - SW'(vg_s5);
		sb_d = (SW'(vb_s5) << 8) - SW'(vb_s5);
		rgb_d.red   = (|sr_d[SW-1:24+FRAC_BITS]) ? 8'hFF : sr_d[16+FRAC_BITS +: 8];
		rgb_d.green = (|sg_d[SW-1:24+FRAC_BITS]) ? 8'hFF : sg_d[16+FRAC_BITS +: 8];
		rgb_d.blue  = (|sb_d[SW-1:24+FRAC_BITS]) ? 8'hFF : sb_d[16+FRAC_BITS +: 8];
	end

	always_ff @(posedge clk) begin
		if (en_s6 && vld_s5) begin
			rgb_s6 <= rgb_d;
		end
	end

	assign rgb_valid = vld_s6;
	assign rgb       = rgb_s6;

	// An accepted item always lands in stage 1.
	`H2R_ASSERT_NEXT(a_accept_lands, hsl_valid && !hsl_stall, vld_s1)
	// Input backs up only when the front stage is occupied.
	`H2R_ASSERT_NOW(a_stall_full, hsl_stall, vld_s1 && vld_s2 && vld_s6)
	// Sector split leaves a remainder within one sector.
	`H2R_ASSERT_NOW(a_rem_range, vld_s1, rem_s1 < 12'(HUE_SECTOR))
	// No channel sum exceeds 1.0 at the working scale.
	`H2R_ASSERT_NOW(a_sum_range, vld_s5,
		(vr_s5 <= (XW'(1) << (16 + FRAC_BITS))) && (vg_s5 <= (XW'(1) << (16 + FRAC_BITS)))
		&& (vb_s5 <= (XW'(1) << (16 + FRAC_BITS))))

endmodule
